FILE: rtl/msalu_pkg.sv
// Shared types and constants for the integer execute unit.
// No dependencies.
`default_nettype none
package msalu_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3,
    OP_MUL = 6'd4, OP_MULU = 6'd5, OP_DIV = 6'd6, OP_DIVU = 6'd7,
    OP_XOR = 6'd8, OP_REM = 6'd9, OP_REMU = 6'd10, OP_NEG = 6'd11,
    OP_NOT = 6'd12, OP_LI = 6'd13, OP_MOVE = 6'd14, OP_MFHI = 6'd15,
    OP_MFLO = 6'd16, OP_SEQ = 6'd17, OP_SGE = 6'd18, OP_SGT = 6'd19,
    OP_SLE = 6'd20, OP_SLT = 6'd21, OP_SNE = 6'd22, OP_B = 6'd23,
    OP_BEQ = 6'd24, OP_BNE = 6'd25, OP_BGE = 6'd26, OP_BLE = 6'd27,
    OP_BGT = 6'd28, OP_BLT = 6'd29, OP_J = 6'd30, OP_JAL = 6'd31,
    OP_JR = 6'd32, OP_JALR = 6'd33
  } op_t;

  localparam logic [5:0] OP_LAST = 6'd33;
  localparam logic [4:0] LINK_REG = 5'd31;

  // Classified operation handed from front to back.
  typedef struct packed {
    logic [5:0]  op;
    logic        valid_op;
    logic        is_div;     // div/divu/rem/remu
    logic        is_signed;
    logic        is_mul;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic        use_imm;
    logic        hi_lo_form;
    logic [31:0] target_address;
    logic [31:0] next_pc;
  } cmd_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic        hilo_written;
    logic        redirect;
    logic [31:0] redirect_target;
    logic        divide_by_zero;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/mips_style_alu_with_register_file.sv
// Top level of the integer execute unit.
// Depends on msalu_pkg, msalu_front, msalu_back.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one decoded instruction word;
//    output channel (out_valid/out_ready) returns exactly one result word.
//  - The front end classifies the opcode and queues up to two words, so
//    the sender keeps going while the back end works or the receiver stalls.
//  - Back end per word: taking it from the queue with a registered read of its
//    source registers, a read state, then simple ops, multiply (three 32x32
//    partials accumulated) or divide/remainder (32 quotient bits, then the
//    result); a divide by zero skips the divider. The back end takes a new
//    word only once the last one has finished; divide is the worst case.
//  - Results wait in an output register; while the receiver stalls the back
//    end holds its finished word and stops taking new ones.
//  - After reset the back end clears every register of the register file; the
//    front end queue fills meanwhile. HI and LO reset to zero.
//  - Register 0 is writable like any other register.
`default_nettype none
module mips_style_alu_with_register_file #(
  parameter int NUM_REGS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  req_type,
  input  wire logic [4:0]  dest_reg,
  input  wire logic [4:0]  src1_reg,
  input  wire logic [4:0]  src2_reg,
  input  wire logic signed [31:0] immediate,
  input  wire logic        use_imm,
  input  wire logic        hi_lo_form,
  input  wire logic [31:0] target_address,
  input  wire logic [31:0] next_pc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             write_enable,
  output logic [4:0]       write_reg,
  output logic signed [31:0] write_value,
  output logic             hilo_written,
  output logic             redirect,
  output logic [31:0]      redirect_target,
  output logic             divide_by_zero
);
  import msalu_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  always_comb begin
    in_cmd = '0;
    in_cmd.op             = req_type;
    in_cmd.dest_reg       = dest_reg;
    in_cmd.src1_reg       = src1_reg;
    in_cmd.src2_reg       = src2_reg;
    in_cmd.immediate      = immediate;
    in_cmd.use_imm        = use_imm;
    in_cmd.hi_lo_form     = hi_lo_form;
    in_cmd.target_address = target_address;
    in_cmd.next_pc        = next_pc;
  end

  msalu_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  msalu_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign write_enable    = res.write_enable;
  assign write_reg       = res.write_reg;
  assign write_value     = res.write_value;
  assign hilo_written    = res.hilo_written;
  assign redirect        = res.redirect;
  assign redirect_target = res.redirect_target;
  assign divide_by_zero  = res.divide_by_zero;
endmodule
`default_nettype wire

FILE: rtl/msalu_front.sv
// Front end: accepts words, classifies the opcode, holds a two-entry queue.
// Depends on msalu_pkg.
`default_nettype none
module msalu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire msalu_pkg::cmd_t   in_cmd,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output msalu_pkg::cmd_t        q_cmd
);
  import msalu_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls = in_cmd;
    cls.valid_op  = (in_cmd.op <= OP_LAST);
    cls.is_div    = (in_cmd.op == OP_DIV) || (in_cmd.op == OP_DIVU) ||
                    (in_cmd.op == OP_REM) || (in_cmd.op == OP_REMU);
    cls.is_mul    = (in_cmd.op == OP_MUL) || (in_cmd.op == OP_MULU);
    cls.is_signed = (in_cmd.op == OP_DIV) || (in_cmd.op == OP_REM) ||
                    (in_cmd.op == OP_MUL);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("push into full queue");
endmodule
`default_nettype wire

FILE: rtl/msalu_div.sv
// Radix-2 restoring divider, unsigned magnitudes, one quotient bit a cycle.
// Depends on nothing.
`default_nettype none
module msalu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  logic [31:0] rem_q, quo_q, dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial     = {rem_q, quo_q[31]} - {1'b0, dvs};
  assign quotient  = quo_q;
  assign remainder = rem_q;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // done stays high with the result until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        done <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/msalu_back.sv
// Back end: register file, HI/LO, ALU, multiplier, divider and output register.
// Depends on msalu_pkg and msalu_div.
`default_nettype none
module msalu_back #(
  parameter int NUM_REGS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire msalu_pkg::cmd_t q_cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output msalu_pkg::res_t      out_res
);
  import msalu_pkg::*;
  localparam int AW = $clog2(NUM_REGS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_READ = 6'b000100,
    S_EXEC  = 6'b001000, S_DIV  = 6'b010000, S_MUL = 6'b100000
  } st_t;

  st_t          state;
  logic [31:0]  rf [NUM_REGS];
  logic [AW-1:0] clr_cnt;
  logic [31:0]  hi_reg, lo_reg;
  cmd_t         cmd;
  logic [31:0]  ra, rb_reg, a, b;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]  wr_data;
  logic         out_free;
  res_t         res;
  logic         fin;
  logic         set_hilo;
  logic [31:0]  new_hi, new_lo;
  // divider
  logic         div_start, div_done, na, nb, bzero;
  logic [31:0]  ua, ub, uq, ur, sq, sr;
  // multiplier (partial products, registered)
  logic [63:0]  prod;
  logic [1:0]   mstep;
  logic [31:0]  mpa, mpb;
  logic [63:0]  pp;
  logic         slt_ab, slt_ba, cond;

  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == S_IDLE);

  // register file reads, registered
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cmd <= q_cmd;
      ra  <= rf[q_cmd.src1_reg[AW-1:0]];
      rb_reg <= rf[q_cmd.src2_reg[AW-1:0]];
    end
  end
  assign a = ra;
  assign b = cmd.use_imm ? cmd.immediate : rb_reg;

  always_ff @(posedge clk) begin
    if (wr_en) rf[wr_addr] <= wr_data;
  end

  assign na = cmd.is_signed && a[31];
  assign nb = cmd.is_signed && b[31];
  assign ua = na ? 32'd0 - a : a;
  assign ub = nb ? 32'd0 - b : b;
  assign bzero = (b == 32'd0);
  assign div_start = (state == S_READ) && cmd.is_div && !bzero;
  assign sq = (na != nb) ? 32'd0 - uq : uq;
  assign sr = na ? 32'd0 - ur : ur;

  msalu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(ua), .divisor(ub),
    .done(div_done), .quotient(uq), .remainder(ur)
  );

  // 64x64 product of sign-extended operands built from three 32x32 partials;
  // low 64 bits cover both signed and unsigned.
  always_comb begin
    unique case (mstep)
      2'd0: begin mpa = a;        mpb = b; end
      2'd1: begin mpa = a;        mpb = (cmd.is_signed && b[31]) ? '1 : '0; end
      2'd2: begin mpa = (cmd.is_signed && a[31]) ? '1 : '0; mpb = b; end
      default: begin mpa = '0; mpb = '0; end
    endcase
  end
  assign pp = {32'd0, mpa} * {32'd0, mpb};

  assign slt_ab = $signed(a) < $signed(b);
  assign slt_ba = $signed(b) < $signed(a);

  always_comb begin
    unique case (cmd.op)
      OP_B:   cond = 1'b1;
      OP_BEQ: cond = (a == b);
      OP_BNE: cond = (a != b);
      OP_BGE: cond = !slt_ab;
      OP_BLE: cond = !slt_ba;
      OP_BGT: cond = slt_ba;
      OP_BLT: cond = slt_ab;
      default: cond = 1'b0;
    endcase
  end

  // result assembly
  always_comb begin
    res = '0;
    set_hilo = 1'b0;
    new_hi = '0;
    new_lo = '0;
    res.write_reg = cmd.dest_reg;
    if (cmd.valid_op) begin
      priority if (cmd.is_div) begin
        res.divide_by_zero = bzero;
        new_lo = bzero ? 32'd0 : sq;
        new_hi = bzero ? 32'd0 : sr;
        if ((cmd.op == OP_REM) || (cmd.op == OP_REMU)) begin
          res.write_enable = 1'b1;
          res.write_value  = new_hi;
        end else if (cmd.hi_lo_form) begin
          set_hilo = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.write_value  = new_lo;
        end
      end else if (cmd.is_mul) begin
        new_hi = prod[63:32];
        new_lo = prod[31:0];
        if (cmd.hi_lo_form) set_hilo = 1'b1;
        else begin
          res.write_enable = 1'b1;
          res.write_value  = prod[31:0];
        end
      end else begin
        unique case (cmd.op)
          OP_ADD, OP_ADDU: begin res.write_enable = 1'b1; res.write_value = a + b; end
          OP_SUB, OP_SUBU: begin res.write_enable = 1'b1; res.write_value = a - b; end
          OP_XOR:  begin res.write_enable = 1'b1; res.write_value = a ^ b; end
          OP_NEG:  begin res.write_enable = 1'b1; res.write_value = 32'd0 - a; end
          OP_NOT:  begin res.write_enable = 1'b1; res.write_value = ~a; end
          OP_LI:   begin res.write_enable = 1'b1; res.write_value = cmd.immediate; end
          OP_MOVE: begin res.write_enable = 1'b1; res.write_value = a; end
          OP_MFHI: begin res.write_enable = 1'b1; res.write_value = hi_reg; end
          OP_MFLO: begin res.write_enable = 1'b1; res.write_value = lo_reg; end
          OP_SEQ:  begin res.write_enable = 1'b1; res.write_value = {31'd0, a == b}; end
          OP_SGE:  begin res.write_enable = 1'b1; res.write_value = {31'd0, !slt_ab}; end
          OP_SGT:  begin res.write_enable = 1'b1; res.write_value = {31'd0, slt_ba}; end
          OP_SLE:  begin res.write_enable = 1'b1; res.write_value = {31'd0, !slt_ba}; end
          OP_SLT:  begin res.write_enable = 1'b1; res.write_value = {31'd0, slt_ab}; end
          OP_SNE:  begin res.write_enable = 1'b1; res.write_value = {31'd0, a != b}; end
          OP_B, OP_BEQ, OP_BNE, OP_BGE, OP_BLE, OP_BGT, OP_BLT: begin
            res.redirect = cond;
            res.redirect_target = cond ? cmd.target_address : 32'd0;
          end
          OP_J: begin res.redirect = 1'b1; res.redirect_target = cmd.target_address; end
          OP_JR: begin res.redirect = 1'b1; res.redirect_target = a; end
          OP_JAL, OP_JALR: begin
            res.redirect = 1'b1;
            res.redirect_target = (cmd.op == OP_JALR) ? a : cmd.target_address;
            res.write_enable = 1'b1;
            res.write_reg    = LINK_REG;
            res.write_value  = cmd.next_pc;
          end
          default: ;
        endcase
      end
    end
    res.hilo_written = set_hilo;
    if (!res.write_enable) begin
      res.write_reg   = '0;
      res.write_value = '0;
    end
  end

  // commit happens in the cycle the result is loaded into the output register
  always_comb begin
    fin = 1'b0;
    unique case (state)
      S_EXEC:  fin = out_free;
      S_DIV:   fin = div_done && out_free;
      S_MUL:   fin = (mstep == 2'd3) && out_free;
      default: fin = 1'b0;
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_en   = fin && res.write_enable;
      wr_addr = res.write_reg[AW-1:0];
      wr_data = res.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) prod <= '0;
    else if (state == S_MUL && mstep != 2'd3) begin
      if (mstep == 2'd0) prod <= prod + pp;
      else prod <= prod + {pp[31:0], 32'd0};
    end
    if (fin) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      hi_reg    <= '0;
      lo_reg    <= '0;
      out_valid <= 1'b0;
      mstep     <= '0;
    end else begin
      if (fin) begin
        out_valid <= 1'b1;
        if (set_hilo) begin
          hi_reg <= new_hi;
          lo_reg <= new_lo;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(NUM_REGS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) state <= S_READ;
        S_READ: begin
          mstep <= '0;
          if (cmd.valid_op && cmd.is_div && !bzero) state <= S_DIV;
          else if (cmd.valid_op && cmd.is_mul) state <= S_MUL;
          else state <= S_EXEC;
        end
        S_EXEC: if (fin) state <= S_IDLE;
        S_DIV: if (fin) state <= S_IDLE;
        S_MUL: begin
          if (mstep != 2'd3) mstep <= mstep + 2'd1;
          else if (fin) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    fin |-> (!out_valid || out_ready)) else $error("result overwrites held word");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> state == S_READ) else $error("take outside idle");
endmodule
`default_nettype wire
